/* hdl/dqkr_pkg.sv */
// shared widths, codes and defaults for the keyed-removal deque
package dqkr_pkg;

    localparam int KEY_W        = 64;
    localparam int PAY_W        = 32;
    localparam int OCC_W        = 8;
    localparam int DEF_CAPACITY = 128;

    typedef enum logic [1:0] {
        CMD_PUSH_TAIL = 2'd0,
        CMD_PUSH_HEAD = 2'd1,
        CMD_POP_HEAD  = 2'd2,
        CMD_REMOVE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

endpackage

/* hdl/dqkr_ram.sv */
// generic single-write, single-read ram with registered read data
module dqkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/dqkr_key_match.sv */
// case-insensitive compare of two eight-byte text keys
module dqkr_key_match
    import dqkr_pkg::*;
(
    input  logic [KEY_W-1:0] i_a,
    input  logic [KEY_W-1:0] i_b,
    output logic             o_match
);

    localparam int NBYTES = KEY_W / 8;

    function automatic logic [7:0] f_fold(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    logic [NBYTES-1:0] w_eq;
    logic [NBYTES-1:0] w_zero;

    always_comb begin
        for (int i = 0; i < NBYTES; i++) begin
            w_eq[i]   = f_fold(i_a[8*i +: 8]) == f_fold(i_b[8*i +: 8]);
            w_zero[i] = f_fold(i_a[8*i +: 8]) == 8'h00;
        end
    end

    // first unequal byte fails, first equal nul byte ends the text
    always_comb begin
        logic done;
        done    = 1'b0;
        o_match = 1'b1;
        for (int i = 0; i < NBYTES; i++) begin
            if (!done) begin
                if (!w_eq[i]) begin
                    o_match = 1'b0;
                    done    = 1'b1;
                end else if (w_zero[i]) begin
                    done = 1'b1;
                end
            end
        end
    end

endmodule

/* hdl/deque_with_keyed_removal.sv */
// top level of the bounded deque with case-insensitive delete by key
// Bounded deque of up to CAPACITY entries (eight-byte text key plus a 32-bit payload handle),
// kept in one ram as a circular buffer with a head pointer and an entry count. Each command
// transaction returns exactly one result transaction: status, the entry taken (zero otherwise)
// and the occupancy after the command. Push tail and push head write the ram on accept and
// then pass through the finish state to the result; pop head reads on accept, takes the entry
// in the pop state, then finishes. Remove by key walks the entries from the head, one ram read
// and one key compare per cycle, then closes the gap behind the match by moving each later
// entry one place toward the head, the write of one entry overlapping the read of the next. A
// remove on an empty queue goes straight to the finish state. The input stalls while a command
// is in flight; a new command is taken while the previous result still waits downstream. No
// clearing pass after reset: only entries below the count are ever used.
module deque_with_keyed_removal
    import dqkr_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // command channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_command,
    input  logic [KEY_W-1:0] i_entry_key,
    input  logic [PAY_W-1:0] i_entry_payload,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_status,
    output logic [KEY_W-1:0] o_taken_key,
    output logic [PAY_W-1:0] o_taken_payload,
    output logic [OCC_W-1:0] o_occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_W + PAY_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT,
        S_FIN
    } t_state;

    // logical position from the head to ram address, one compare and subtract
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] lidx);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(lidx);
        if (s >= (CW+1)'(CAPACITY)) begin
            s = s - (CW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    t_state           r_state,   n_state;
    logic [CW-1:0]    r_count,   n_count;
    logic [AW-1:0]    r_head,    n_head;
    logic [CW-1:0]    r_idx,     n_idx;
    logic [KEY_W-1:0] r_key,     n_key;
    t_status          r_res_st,  n_res_st;
    logic [KEY_W-1:0] r_res_key, n_res_key;
    logic [PAY_W-1:0] r_res_pay, n_res_pay;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_status,  n_status;
    logic [KEY_W-1:0] r_tkey,    n_tkey;
    logic [PAY_W-1:0] r_tpay,    n_tpay;
    logic [OCC_W-1:0] r_occ,     n_occ;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [EW-1:0]    w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [EW-1:0]    w_rdata;
    logic             w_match;
    logic             w_full;
    logic             w_empty;
    logic [AW-1:0]    w_head_dec;
    logic [AW-1:0]    w_head_inc;
    logic [CW-1:0]    w_idx1;
    logic [CW-1:0]    w_idx2;
    logic [31:0]      w_count32;

    dqkr_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // the single compare unit, used by the remove scan: stored key from the ram against the command key
    dqkr_key_match u_match (
        .i_a     (w_rdata[EW-1 -: KEY_W]),
        .i_b     (r_key),
        .o_match (w_match)
    );

    assign w_full     = r_count == CW'(CAPACITY);
    assign w_empty    = r_count == '0;
    assign w_head_dec = (r_head == '0) ? AW'(CAPACITY - 1) : AW'(r_head - AW'(1));
    assign w_head_inc = (r_head == AW'(CAPACITY - 1)) ? '0 : AW'(r_head + AW'(1));
    assign w_idx1     = CW'(r_idx + CW'(1));
    assign w_idx2     = CW'(r_idx + CW'(2));
    assign w_count32  = 32'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_key       = r_key;
        n_res_st    = r_res_st;
        n_res_key   = r_res_key;
        n_res_pay   = r_res_pay;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_tkey      = r_tkey;
        n_tpay      = r_tpay;
        n_occ       = r_occ;
        w_we        = 1'b0;
        w_waddr     = f_phys(r_head, r_count);
        w_wdata     = {i_entry_key, i_entry_payload};
        w_raddr     = f_phys(r_head, '0);

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_key = '0;
                    n_res_pay = '0;
                    n_res_st  = ST_OK;
                    n_key     = i_entry_key;
                    n_idx     = '0;
                    n_state   = S_FIN;
                    case (t_cmd'(i_command))
                        CMD_PUSH_TAIL: begin
                            if (w_full) begin
                                n_res_st = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = f_phys(r_head, r_count);
                                n_count = CW'(r_count + CW'(1));
                            end
                        end
                        CMD_PUSH_HEAD: begin
                            if (w_full) begin
                                n_res_st = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_head_dec;
                                n_head  = w_head_dec;
                                n_count = CW'(r_count + CW'(1));
                            end
                        end
                        CMD_POP_HEAD: begin
                            if (w_empty) begin
                                n_res_st = ST_EMPTY;
                            end else begin
                                w_raddr = r_head;
                                n_state = S_POP;
                            end
                        end
                        CMD_REMOVE: begin
                            if (w_empty) begin
                                n_res_st = ST_NOT_FOUND;
                            end else begin
                                w_raddr = r_head;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_res_key = w_rdata[EW-1 -: KEY_W];
                n_res_pay = w_rdata[PAY_W-1:0];
                n_head    = w_head_inc;
                n_count   = CW'(r_count - CW'(1));
                n_state   = S_FIN;
            end
            S_SCAN: begin
                // read ahead the next entry while comparing this one
                w_raddr = f_phys(r_head, w_idx1);
                if (w_match) begin
                    n_res_key = w_rdata[EW-1 -: KEY_W];
                    n_res_pay = w_rdata[PAY_W-1:0];
                    n_res_st  = ST_OK;
                    if (w_idx1 < r_count) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_count = CW'(r_count - CW'(1));
                        n_state = S_FIN;
                    end
                end else if (w_idx1 == r_count) begin
                    n_res_st = ST_NOT_FOUND;
                    n_state  = S_FIN;
                end else begin
                    n_idx = w_idx1;
                end
            end
            S_SHIFT: begin
                // move the entry behind the gap one place toward the head
                w_we    = 1'b1;
                w_waddr = f_phys(r_head, r_idx);
                w_wdata = w_rdata;
                w_raddr = f_phys(r_head, w_idx2);
                n_idx   = w_idx1;
                if (w_idx2 >= r_count) begin
                    n_count = CW'(r_count - CW'(1));
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_st;
                    n_tkey      = r_res_key;
                    n_tpay      = r_res_pay;
                    n_occ       = w_count32[OCC_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_res_st  <= n_res_st;
        r_res_key <= n_res_key;
        r_res_pay <= n_res_pay;
        r_status  <= n_status;
        r_tkey    <= n_tkey;
        r_tpay    <= n_tpay;
        r_occ     <= n_occ;
    end

    // only idle takes a command transaction
    assign o_in_stall      = r_state != S_IDLE;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_taken_key     = r_tkey;
    assign o_taken_payload = r_tpay;
    assign o_occupancy     = r_occ;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for the keyed-removal deque: result scoreboard class plus stimulus tasks

import dqkr_pkg::*;

typedef struct packed {
    t_status          status;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [OCC_W-1:0] occupancy;
} t_deque_result;

// mirror of the deque contents and the results it owes
class deque_scoreboard;
    logic [KEY_W-1:0] held_keys[$];
    logic [PAY_W-1:0] held_payloads[$];
    t_deque_result    awaited[$];
    int               mismatches;

    function logic [7:0] fold_case(logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a) return c + 8'h20;
        return c;
    endfunction

    // byte-wise compare, case folded, stops at a shared zero byte
    function bit keys_equal(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        logic [7:0] ca;
        logic [7:0] cb;
        for (int i = 0; i < 8; i++) begin
            ca = fold_case(a[8*i +: 8]);
            cb = fold_case(b[8*i +: 8]);
            if (ca != cb) return 1'b0;
            if (ca == 8'h00) return 1'b1;
        end
        return 1'b1;
    endfunction

    function int depth();
        return held_keys.size();
    endfunction

    function void note_command(t_cmd cmd, logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
        t_deque_result r;
        int            hit;
        r.status  = ST_OK;
        r.key     = '0;
        r.payload = '0;
        case (cmd)
            CMD_PUSH_TAIL: begin
                if (held_keys.size() >= DEF_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    held_keys.push_back(key);
                    held_payloads.push_back(payload);
                end
            end
            CMD_PUSH_HEAD: begin
                if (held_keys.size() >= DEF_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    held_keys.push_front(key);
                    held_payloads.push_front(payload);
                end
            end
            CMD_POP_HEAD: begin
                if (held_keys.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.key     = held_keys.pop_front();
                    r.payload = held_payloads.pop_front();
                end
            end
            default: begin
                r.status = ST_NOT_FOUND;
                hit      = -1;
                for (int i = 0; i < held_keys.size(); i++) begin
                    if (keys_equal(held_keys[i], key)) begin
                        hit = i;
                        break;
                    end
                end
                if (hit >= 0) begin
                    r.status  = ST_OK;
                    r.key     = held_keys[hit];
                    r.payload = held_payloads[hit];
                    held_keys.delete(hit);
                    held_payloads.delete(hit);
                end
            end
        endcase
        r.occupancy = OCC_W'(held_keys.size());
        awaited.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [KEY_W-1:0] key,
                               logic [PAY_W-1:0] payload, logic [OCC_W-1:0] occupancy);
        t_deque_result want;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: status %0d key %h payload %h occupancy %0d",
                         status, key, payload, occupancy);
            return;
        end
        want = awaited.pop_front();
        if (status !== want.status || key !== want.key || payload !== want.payload ||
            occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp/act: status %0d/%0d key %h/%h pay %h/%h occ %0d/%0d",
                         want.status, status, want.key, key, want.payload, payload,
                         want.occupancy, occupancy);
        end
    endfunction
endclass

module tb_top;

    localparam int QUIET_LIMIT  = 4000;  // longest remove plus long stalls, several times over
    localparam int DRAIN_CYCLES = 300;   // covers a full-depth remove
    localparam int RANDOM_ITEMS = 1050;
    localparam int POOL_SIZE    = 10;

    typedef enum int {
        SEG_FILL,
        SEG_MIX_A,
        SEG_DRAIN,
        SEG_MIX_B
    } t_seg_mode;

    // clock and reset
    logic clk;
    logic rst_n = 1'b0;

    // command channel, known from time zero
    logic             in_valid   = 1'b0;
    logic [1:0]       command    = CMD_PUSH_TAIL;
    logic [KEY_W-1:0] entry_key  = '0;
    logic [PAY_W-1:0] entry_pay  = '0;
    logic             in_stall;

    // result channel
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic [1:0]       status;
    logic [KEY_W-1:0] taken_key;
    logic [PAY_W-1:0] taken_pay;
    logic [OCC_W-1:0] occupancy;

    // idling controls, changed per segment
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int sent           = 0;

    // keys that pushes and removes draw from, so removes find something
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    deque_scoreboard sb = new();

    deque_with_keyed_removal #(
        .CAPACITY(DEF_CAPACITY)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_command       (command),
        .i_entry_key     (entry_key),
        .i_entry_payload (entry_pay),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_taken_key     (taken_key),
        .o_taken_payload (taken_pay),
        .o_occupancy     (occupancy)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // pack text into a key, first character in the low byte
    function automatic logic [KEY_W-1:0] text_key(string s);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < 8; i++) k[8*i +: 8] = s[i];
        return k;
    endfunction

    // mostly letters of both cases, some digits, now and then the neighbors of the letter ranges
    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            case ($urandom_range(3))
                0:       return 8'h40;
                1:       return 8'h5b;
                2:       return 8'h60;
                default: return 8'h7b;
            endcase
        end
        if (pick < 15) return 8'h30 + 8'($urandom_range(9));
        if (pick < 57) return 8'h41 + 8'($urandom_range(25));
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    // text of zero to eight characters, zero padded
    function automatic logic [KEY_W-1:0] random_text();
        logic [KEY_W-1:0] k;
        int               len;
        k   = '0;
        len = $urandom_range(8);
        for (int i = 0; i < len; i++) k[8*i +: 8] = random_char();
        return k;
    endfunction

    // flip case bits at random and scribble past the terminator
    function automatic logic [KEY_W-1:0] key_variant(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] v;
        bit               ended;
        v     = k;
        ended = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (ended) begin
                if ($urandom_range(1) == 1) v[8*i +: 8] = 8'($urandom());
            end else if (v[8*i +: 8] == 8'h00) begin
                ended = 1'b1;
            end else if (v[8*i + 6] && $urandom_range(2) == 0) begin
                v[8*i + 5] = ~v[8*i + 5];
            end
        end
        return v;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(int noise_pct);
        if ($urandom_range(99) < noise_pct) return {$urandom(), $urandom()};
        return key_variant(key_pool[$urandom_range(POOL_SIZE - 1)]);
    endfunction

    // one command transaction; valid stays up across back-to-back transactions
    task automatic send_command(input t_cmd cmd, input logic [KEY_W-1:0] key,
                                input logic [PAY_W-1:0] pay);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        entry_key <= key;
        entry_pay <= pay;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_command(cmd, key, pay);
    endtask

    // push share, pop share, the rest is remove by key
    task automatic random_command(input int push_pct, input int pop_pct);
        int   roll;
        t_cmd cmd;
        roll = $urandom_range(99);
        if (roll < push_pct)
            cmd = ($urandom_range(1) == 1) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL;
        else if (roll < push_pct + pop_pct)
            cmd = CMD_POP_HEAD;
        else
            cmd = CMD_REMOVE;
        send_command(cmd, (cmd == CMD_REMOVE) ? pick_key(15) : pick_key(10), $urandom());
        sent++;
    endtask

    // result side: check every accepted transaction, stall at random
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, taken_key, taken_pay, occupancy);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("deque_with_keyed_removal test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int        seg;
        int        guard;
        int        plan;
        t_seg_mode mode;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        send_command(CMD_POP_HEAD, '0, '0);                         // pop on empty
        send_command(CMD_REMOVE, text_key("alpha"), '0);            // remove on empty
        send_command(CMD_PUSH_TAIL, '1, '1);                        // all-ones key and payload
        send_command(CMD_PUSH_HEAD, '0, '0);                        // all-zero key at the head
        send_command(CMD_PUSH_TAIL, text_key("Alpha"), 32'h0000_0011);
        send_command(CMD_PUSH_TAIL, text_key("ALPHA"), 32'h0000_0022);
        // garbage after the terminator is stored as is
        send_command(CMD_PUSH_HEAD, text_key("bravo") | {16'h7a79, 48'h0}, 32'h8000_0033);
        send_command(CMD_PUSH_TAIL, text_key("x["), 32'h0000_0044);
        send_command(CMD_PUSH_TAIL, text_key("Zulu@Zz!"), 32'h7fff_ffff);
        send_command(CMD_REMOVE, text_key("aLpHa"), '0);            // first of two matches only
        send_command(CMD_REMOVE, text_key("BRAVO") | {16'h5151, 48'h0}, '0);  // past zero ignored
        send_command(CMD_REMOVE, text_key("X{"), '0);               // brackets do not fold
        send_command(CMD_REMOVE, text_key("x["), '0);
        send_command(CMD_REMOVE, text_key("zULU`zZ!"), '0);         // at-sign does not fold
        send_command(CMD_REMOVE, text_key("zULU@zZ!"), '0);         // eight equal bytes
        send_command(CMD_REMOVE, '0, '0);                           // all-zero key matches
        send_command(CMD_REMOVE, '1, '0);
        send_command(CMD_REMOVE, text_key("nothere"), '0);          // no match
        send_command(CMD_POP_HEAD, '0, '0);                         // the remaining alpha
        send_command(CMD_POP_HEAD, '0, '0);                         // empty again

        // random part: fill to full, mix, drain to empty, mix; idling varies per segment
        seg = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = t_seg_mode'(seg % 4);
            plan = (seg + seg / 4) % 4;
            case (plan)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            guard = 0;
            case (mode)
                SEG_FILL: begin
                    // fresh key pool each fill, one entry always eight characters long
                    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_text();
                    for (int i = 0; i < 8; i++) key_pool[0][8*i +: 8] = random_char();
                    while (sb.depth() < DEF_CAPACITY && guard < 400) begin
                        random_command(85, 5);
                        guard++;
                    end
                    repeat (4) random_command(100, 0);              // pushes into a full queue
                end
                SEG_DRAIN: begin
                    while (sb.depth() > 0 && guard < 400) begin
                        random_command(5, 50);
                        guard++;
                    end
                    repeat (3) random_command(0, 50);               // pops and removes on empty
                end
                default: begin
                    repeat (60) random_command(34, 33);
                end
            endcase
            seg++;
        end

        // let everything drain, then a latency's worth of quiet for strays
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("deque_with_keyed_removal test passed");
        else
            $display("deque_with_keyed_removal test failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/dqkr_pkg.sv
hdl/dqkr_ram.sv
hdl/dqkr_key_match.sv
hdl/deque_with_keyed_removal.sv
bench/tb_top.sv
